[design/mbet_pkg.sv]
`default_nettype none
package mbet_pkg;
    localparam int DATA_W = 32;
    localparam int PROD_W = 64;

    // Register word indices (taken from paddr[4:2]).
    localparam logic [2:0] REG_OFFSET_RE = 3'd0;
    localparam logic [2:0] REG_OFFSET_IM = 3'd1;
    localparam logic [2:0] REG_MAX_ROUNDS = 3'd2;
    localparam logic [2:0] REG_EXPONENT = 3'd3;
    localparam logic [2:0] REG_CONJUGATE = 3'd4;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        begin
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
            if (s[DATA_W] != s[DATA_W-1])
                sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
            else
                sat_add = s[DATA_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

[design/mbet_isqrt.sv]
`default_nettype none
// Restoring square root, one result bit per cycle.
module mbet_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] trial;
    logic [35:0] part;

    always_comb
    begin
        rad_next = rad_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // The remainder takes the next two radicand bits each step.
        part = {rem_reg, rad_reg[63:62]};
        trial = {2'b00, res_reg, 2'b01};
        if (start)
        begin
            rad_next = radicand;
            rem_next = 34'd0;
            res_next = 32'd0;
            cnt_next = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (part >= trial)
            begin
                rem_next = 34'(part - trial);
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = part[33:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            rad_next = {rad_reg[61:0], 2'b00};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule
`default_nettype wire

[design/mandelbrot_escape_time.sv]
// One point at a time on the one shared 32x32 multiplier and the 32-step root: in_ready
//   is high only while the sequencer is idle, so a new point is taken only once the last
//   one has left the sequencer.
// A finished result waits in the output register while the next point is already taken.
// Reset (rst_n, asynchronous, low): offset 0, max_rounds 30, exponent 2, conjugate 0, idle.
`default_nettype none
module mandelbrot_escape_time #(
    parameter int FRAC_BITS    = 22,
    parameter int MAX_EXPONENT = 8,
    parameter int ROUND_BITS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic signed [31:0] point_re,
    input  wire logic signed [31:0] point_im,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             in_set,
    output logic [15:0]      rounds_done,
    output logic [31:0]      final_modulus
);
    localparam int EXP_W = $clog2(MAX_EXPONENT + 1);
    // A shifted product of two Q values needs 64 - FRAC_BITS bits signed.
    localparam int TERM_W = 64 - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CONJ, S_MAG_A, S_MAG_B, S_MAG_CMP, S_P_SETUP,
        S_MUL, S_ADDC, S_FMAG_A, S_FMAG_B, S_FMAG_SUM, S_SQRT_GO, S_SQRT_WAIT, S_OUT
    } state_t;

    // Configuration registers.
    logic signed [31:0] off_re_reg, off_im_reg;
    logic [15:0] max_rounds_reg;
    logic [3:0]  exponent_reg;
    logic        conj_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_re_reg <= '0;
            off_im_reg <= '0;
            max_rounds_reg <= 16'd30;
            exponent_reg <= 4'd2;
            conj_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                mbet_pkg::REG_OFFSET_RE: off_re_reg <= pwdata;
                mbet_pkg::REG_OFFSET_IM: off_im_reg <= pwdata;
                mbet_pkg::REG_MAX_ROUNDS: max_rounds_reg <= pwdata[15:0];
                mbet_pkg::REG_EXPONENT: exponent_reg <= pwdata[3:0];
                mbet_pkg::REG_CONJUGATE: conj_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            mbet_pkg::REG_OFFSET_RE: prdata = off_re_reg;
            mbet_pkg::REG_OFFSET_IM: prdata = off_im_reg;
            mbet_pkg::REG_MAX_ROUNDS: prdata = {16'd0, max_rounds_reg};
            mbet_pkg::REG_EXPONENT: prdata = {28'd0, exponent_reg};
            mbet_pkg::REG_CONJUGATE: prdata = {31'd0, conj_reg};
            default: prdata = 32'd0;
        endcase
    end

    // Datapath registers.
    state_t state_reg;
    logic signed [31:0] cre_reg, cim_reg, zre_reg, zim_reg, pre_reg, pim_reg;
    logic signed [63:0] acc_reg;    // |z|^2 accumulator
    logic signed [TERM_W-1:0] ac_s_reg, bd_s_reg, ad_s_reg;
    logic [1:0]  mstep_reg;
    logic [EXP_W-1:0] kcnt_reg, e_reg;
    logic [ROUND_BITS-1:0] n_reg, limit_reg;
    logic        inside_reg;
    logic        out_valid_reg;
    logic [15:0] rounds_out_reg;
    logic        in_set_out_reg;
    logic [31:0] mod_out_reg;

    // The one shared multiplier; product registered.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_sh;
    logic signed [TERM_W-1:0] term_sh;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign term_sh = prod_sh[TERM_W-1:0];

    // Operand select: S_MAG_A/FMAG_A use zre^2, _B zim^2, S_MUL steps 0..3.
    always_comb
    begin
        mul_a = zre_reg;
        mul_b = zre_reg;
        case (state_reg)
            S_MAG_B, S_FMAG_B:
            begin
                mul_a = zim_reg;
                mul_b = zim_reg;
            end
            S_MUL:
            begin
                case (mstep_reg)
                    2'd0: begin mul_a = pre_reg; mul_b = zre_reg; end
                    2'd1: begin mul_a = pim_reg; mul_b = zim_reg; end
                    2'd2: begin mul_a = pre_reg; mul_b = zim_reg; end
                    default: begin mul_a = pim_reg; mul_b = zre_reg; end
                endcase
            end
            default: ;
        endcase
    end

    function automatic logic signed [31:0] sat_term(input logic signed [SUM_W-1:0] v);
        if (!v[SUM_W-1] && (|v[SUM_W-2:31]))
            sat_term = 32'sh7FFFFFFF;
        else if (v[SUM_W-1] && !(&v[SUM_W-2:31]))
            sat_term = 32'sh80000000;
        else
            sat_term = v[31:0];
    endfunction

    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic [63:0] thresh;
    assign thresh = 64'd4 << (2 * FRAC_BITS);

    mbet_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .radicand(acc_reg), .done(sq_done), .root(sq_root)
    );
    assign sq_start = (state_reg == S_SQRT_GO);

    // The product is registered: each multiply step issues its operands, and the
    // product is captured from the register in the next cycle.
    logic cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            cap_reg <= 1'b0;
            mstep_reg <= 2'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        cre_reg <= point_re;
                        cim_reg <= point_im;
                        zre_reg <= mbet_pkg::sat_add(point_re, off_re_reg);
                        zim_reg <= mbet_pkg::sat_add(point_im, off_im_reg);
                        limit_reg <= ROUND_BITS'(max_rounds_reg);
                        e_reg <= (exponent_reg > MAX_EXPONENT) ? EXP_W'(MAX_EXPONENT)
                                                               : EXP_W'(exponent_reg);
                        n_reg <= '0;
                        inside_reg <= 1'b1;
                        state_reg <= S_INIT;
                    end
                S_INIT:
                    state_reg <= (n_reg == limit_reg) ? S_FMAG_A : S_CONJ;
                S_CONJ:
                begin
                    if (conj_reg)
                        zim_reg <= (zim_reg == 32'sh80000000) ? 32'sh7FFFFFFF : -zim_reg;
                    state_reg <= S_MAG_A;
                    cap_reg <= 1'b0;
                end
                S_MAG_A, S_FMAG_A:
                begin
                    state_reg <= (state_reg == S_MAG_A) ? S_MAG_B : S_FMAG_B;
                end
                S_MAG_B, S_FMAG_B:
                begin
                    acc_reg <= prod_reg;
                    state_reg <= (state_reg == S_MAG_B) ? S_MAG_CMP : S_FMAG_SUM;
                end
                S_MAG_CMP:
                begin
                    if (64'(acc_reg) + 64'(prod_reg) > thresh)
                    begin
                        inside_reg <= 1'b0;
                        acc_reg <= acc_reg + prod_reg;
                        state_reg <= S_SQRT_GO;
                    end
                    else
                    begin
                        pre_reg <= 32'sd1 <<< FRAC_BITS;
                        pim_reg <= '0;
                        kcnt_reg <= '0;
                        state_reg <= S_P_SETUP;
                    end
                end
                S_P_SETUP:
                begin
                    mstep_reg <= 2'd0;
                    cap_reg <= 1'b0;
                    state_reg <= (kcnt_reg == e_reg) ? S_ADDC : S_MUL;
                end
                S_MUL:
                begin
                    // Issue a step, capture it next cycle.
                    if (!cap_reg)
                        cap_reg <= 1'b1;
                    else
                    begin
                        cap_reg <= 1'b0;
                        case (mstep_reg)
                            2'd0: ac_s_reg <= term_sh;
                            2'd1: bd_s_reg <= term_sh;
                            2'd2: ad_s_reg <= term_sh;
                            default:
                            begin
                                pre_reg <= sat_term(SUM_W'(ac_s_reg) - SUM_W'(bd_s_reg));
                                pim_reg <= sat_term(SUM_W'(ad_s_reg) + SUM_W'(term_sh));
                                kcnt_reg <= kcnt_reg + 1'b1;
                            end
                        endcase
                        if (mstep_reg == 2'd3)
                            state_reg <= S_P_SETUP;
                        mstep_reg <= mstep_reg + 2'd1;
                    end
                end
                S_ADDC:
                begin
                    zre_reg <= mbet_pkg::sat_add(pre_reg, cre_reg);
                    zim_reg <= mbet_pkg::sat_add(pim_reg, cim_reg);
                    n_reg <= n_reg + 1'b1;
                    state_reg <= S_INIT;
                end
                S_FMAG_SUM:
                begin
                    acc_reg <= acc_reg + prod_reg;
                    state_reg <= S_SQRT_GO;
                end
                S_SQRT_GO:
                    state_reg <= S_SQRT_WAIT;
                S_SQRT_WAIT:
                    if (sq_done)
                        state_reg <= S_OUT;
                S_OUT:
                    // The root holds until the next start, so the result can
                    // wait here for the output register to free up.
                    if (!out_valid_reg || out_ready)
                    begin
                        mod_out_reg <= sq_root;
                        in_set_out_reg <= inside_reg;
                        rounds_out_reg <= 16'(n_reg);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign in_set = in_set_out_reg;
    assign rounds_done = rounds_out_reg;
    assign final_modulus = mod_out_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_rounds_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (n_reg <= limit_reg)) else $error("round overrun");
`endif
endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps

// One expected result of the escape-time iteration.
typedef struct {
    bit              in_set;
    bit [15:0]       rounds;
    bit [31:0]       modulus;
} escape_result_t;

class EscapeScoreboard;
    int              ofs_re;
    int              ofs_im;
    int unsigned     max_rounds;
    int unsigned     exponent;
    bit              conjugate;
    escape_result_t  pending_escapes[$];
    int              mismatches;
    int              results_seen;

    function new();
        ofs_re = 0;
        ofs_im = 0;
        max_rounds = 30;
        exponent = 2;
        conjugate = 0;
        mismatches = 0;
        results_seen = 0;
    endfunction

    function int sat(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    // Fixed-point complex multiply; each partial product is floored.
    function void cmul(int a, int b, int c, int d, output int re, output int im);
        longint ac;
        longint bd;
        longint ad;
        longint bc;
        ac = (longint'(a) * longint'(c)) >>> 22;
        bd = (longint'(b) * longint'(d)) >>> 22;
        ad = (longint'(a) * longint'(d)) >>> 22;
        bc = (longint'(b) * longint'(c)) >>> 22;
        re = sat(ac - bd);
        im = sat(ad + bc);
    endfunction

    function bit [63:0] mag2(int re, int im);
        bit [63:0] r;
        bit [63:0] i;
        r = longint'(re) * longint'(re);
        i = longint'(im) * longint'(im);
        return r + i;
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function void note_point(int cre, int cim);
        int              zre;
        int              zim;
        int              pre;
        int              pim;
        int unsigned     limit;
        int unsigned     e;
        int unsigned     n;
        bit [63:0]       m;
        escape_result_t  r;
        zre = sat(longint'(cre) + ofs_re);
        zim = sat(longint'(cim) + ofs_im);
        limit = max_rounds & 32'hFFFF;
        e = (exponent > 8) ? 8 : exponent;
        r.in_set = 1;
        for (n = 0; n < limit; n++)
        begin
            pre = 32'h00400000;
            pim = 0;
            if (conjugate)
                zim = sat(-longint'(zim));
            if (mag2(zre, zim) > (64'd4 << 44))
            begin
                r.in_set = 0;
                break;
            end
            for (int k = 0; k < e; k++)
                cmul(pre, pim, zre, zim, pre, pim);
            zre = sat(longint'(pre) + cre);
            zim = sat(longint'(pim) + cim);
        end
        m = isqrt(mag2(zre, zim));
        if (m > 64'hFFFFFFFF)
            m = 64'hFFFFFFFF;
        r.rounds = n[15:0];
        r.modulus = m[31:0];
        pending_escapes.push_back(r);
    endfunction

    function void check_result(bit s, bit [15:0] rd, bit [31:0] md);
        escape_result_t x;
        results_seen++;
        if (pending_escapes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result beat with nothing expected (%0d %0d %h)", s, rd, md);
            return;
        end
        x = pending_escapes.pop_front();
        if (x.in_set !== s || x.rounds !== rd || x.modulus !== md)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: result %0d expected in_set=%0d rounds=%0d mod=%h,",
                          " got %0d %0d %h"},
                         results_seen, x.in_set, x.rounds, x.modulus, s, rd, md);
        end
    endfunction

    function int pending();
        return pending_escapes.size();
    endfunction
endclass

module tb;
    // The slowest point here runs 200 rounds at exponent 8.
    localparam int STALL_LIMIT = 80000;
    // Long enough for two of the slowest random-phase points to finish.
    localparam int HOLD_CYCLES = 8000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic        out_valid;
    logic        out_ready;
    logic        in_set;
    logic [15:0] rounds_done;
    logic [31:0] final_modulus;

    EscapeScoreboard sb;
    bit  idle_on;
    bit  hold_req;
    int  points_sent;
    int  phases_run;
    int  quiet_cycles;

    mandelbrot_escape_time dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_re(point_re), .point_im(point_im),
        .out_valid(out_valid), .out_ready(out_ready),
        .in_set(in_set), .rounds_done(rounds_done), .final_modulus(final_modulus)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Register write over the APB port: setup cycle, then access cycle. The
    // scoreboard copy of the register follows the same masking as the block.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            mbet_pkg::REG_OFFSET_RE:  sb.ofs_re = int'(value);
            mbet_pkg::REG_OFFSET_IM:  sb.ofs_im = int'(value);
            mbet_pkg::REG_MAX_ROUNDS: sb.max_rounds = 32'(value[15:0]);
            mbet_pkg::REG_EXPONENT:   sb.exponent = 32'(value[3:0]);
            mbet_pkg::REG_CONJUGATE:  sb.conjugate = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic set_config(int ore, int oim, int unsigned mr, int unsigned ex, bit cj);
        write_reg(mbet_pkg::REG_OFFSET_RE, ore);
        write_reg(mbet_pkg::REG_OFFSET_IM, oim);
        write_reg(mbet_pkg::REG_MAX_ROUNDS, mr);
        write_reg(mbet_pkg::REG_EXPONENT, ex);
        write_reg(mbet_pkg::REG_CONJUGATE, 32'(cj));
    endtask

    // Offer one point; called at a falling edge and returns at a falling edge.
    // A gap, when taken, drops valid before the new beat is raised, so valid
    // is never lowered and raised in the same step.
    task automatic send_point(int re, int im);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 10))
                @(negedge clk);
        end
        in_valid = 1;
        point_re = re;
        point_im = im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(re, im);
        points_sent++;
        @(negedge clk);
    endtask

    // Wait until every beat has come back, then let the block settle before
    // the next register change.
    task automatic drain();
        in_valid = 0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
        phases_run++;
    endtask

    // Random point: mostly inside the interesting square of half-width 2.5, the
    // rest anywhere in the 32-bit range so every bit toggles.
    task automatic rand_point(output int re, output int im);
        if ($urandom_range(0, 3) == 0)
        begin
            re = $urandom;
            im = $urandom;
        end
        else
        begin
            re = int'($urandom_range(0, 20971520)) - 10485760;
            im = int'($urandom_range(0, 20971520)) - 10485760;
        end
    endtask

    // Result monitor: outputs are sampled at the rising edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(in_set, rounds_done, final_modulus);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so that
    // the block fills and holds its input ready low.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready = 0;
                repeat ($urandom_range(1, 10))
                    @(negedge clk);
            end
            out_ready = 1;
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ERROR: no beat for %0d cycles", STALL_LIMIT);
                $display("FAIL mandelbrot_escape_time");
                $finish;
            end
        end
    end

    initial
    begin
        int re;
        int im;
        sb = new();
        idle_on = 1;
        hold_req = 0;
        points_sent = 0;
        phases_run = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        point_re = 0;
        point_im = 0;
        repeat (8)
            @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed, reset settings: origin, field extremes, boundary points.
        send_point(0, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'h7FFFFFFF, 32'h80000000);
        send_point(-32'sd4194304, 0);
        send_point(-32'sd8388608, 0);
        send_point(32'sd1048576, 32'sd2097152);
        send_point(-32'sd3145728, 32'sd419430);
        drain();

        // Saturating offset, no rounds at all, exponent zero, conjugation.
        set_config(32'h7FFFFFFF, 32'h80000000, 0, 0, 1);
        send_point(32'h7FFFFFFF, 32'h80000000);
        send_point(32'h80000000, 32'h7FFFFFFF);
        send_point(0, 0);
        drain();
        set_config(32'h80000000, 0, 12, 0, 1);
        send_point(0, 32'h80000000);
        send_point(32'h7FFFFFFF, 32'h80000000);
        send_point(-32'sd1048576, 32'sd1048576);
        drain();

        // Largest round limit with points that escape early; exponent above
        // the maximum folds to the maximum.
        set_config(0, 0, 65535, 15, 0);
        send_point(32'h7FFFFFFF, 0);
        send_point(32'sd12582912, 32'sd12582912);
        send_point(32'h80000000, 32'h80000000);
        drain();

        // Exponent one, and the deepest in-set points of the directed part.
        set_config(32'sd1000, -32'sd1000, 200, 1, 0);
        send_point(0, 0);
        send_point(32'sd4194, -32'sd4194);
        drain();
        set_config(0, 0, 200, 8, 1);
        send_point(0, 0);
        send_point(-32'sd419430, 32'sd419430);
        drain();

        // Random phases: new settings each phase, random points. The fifth
        // phase holds the receiver off for a long stretch; the last two run
        // with no idling at all.
        for (int ph = 0; ph < 12; ph++)
        begin
            int ore;
            int oim;
            int unsigned mr;
            if ($urandom_range(0, 2) == 0)
            begin
                ore = $urandom;
                oim = $urandom;
            end
            else
            begin
                ore = int'($urandom_range(0, 4194304)) - 2097152;
                oim = int'($urandom_range(0, 4194304)) - 2097152;
            end
            mr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
            set_config(ore, oim, mr, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            if (ph >= 10)
                idle_on = 0;
            if (ph == 4)
                hold_req = 1;
            for (int i = 0; i < 150; i++)
            begin
                rand_point(re, im);
                send_point(re, im);
            end
            drain();
        end

        if (sb.pending() != 0)
        begin
            sb.mismatches++;
            $display("ERROR: %0d expected results never arrived", sb.pending());
        end
        $display("Covered %0d points over %0d register settings, %0d results checked.",
                 points_sent, phases_run, sb.results_seen);
        $display("Settings spanned offset extremes, 0 to 65535 rounds, exponents 0 to 15.");
        if (sb.mismatches == 0)
            $display("PASS mandelbrot_escape_time");
        else
            $display("FAIL mandelbrot_escape_time");
        $finish;
    end
endmodule

[files.f]
design/mbet_pkg.sv
design/mbet_isqrt.sv
design/mandelbrot_escape_time.sv
tb/sv/tb.sv
